// ----- sv/burning_ship_escape_time_top_assert.svh -----
// assertion macros for the escape-time block
`ifndef BURNING_SHIP_ESCAPE_TIME_TOP_ASSERT_SVH
`define BURNING_SHIP_ESCAPE_TIME_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BSE_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define BSE_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define BSE_ASSERT_IMP(lbl, a, c)
`define BSE_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ----- sv/bse_pkg.sv -----
`default_nettype none
package bse_pkg;
  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } bse_in_t;

  typedef struct packed {
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic [9:0] iter_count;
    logic [7:0] blue_level;
    logic       on_canvas;
  } bse_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch pixel, start mapping
    logic map_re;   // capture real mapping result
    logic map_im;   // capture imaginary mapping result
    logic init_z;   // set start point
    logic mul;      // register products
    logic upd;      // update z
    logic div_start;
    logic div_step;
  } bse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cont;     // iteration may continue
    logic map_done;
    logic div_done;
  } bse_sts_t;

  localparam int CfgReMin = 0;
  localparam int CfgReMax = 1;
  localparam int CfgImMin = 2;
  localparam int CfgImMax = 3;
  localparam int CfgLimit = 4;
  localparam int CfgMode  = 5;
  localparam int CfgStRe  = 6;
  localparam int CfgStIm  = 7;

  localparam logic signed [31:0] ReMinRst = 32'shDE666666;
  localparam logic signed [31:0] ReMaxRst = 32'sh0999999A;
  localparam logic signed [31:0] ImMinRst = 32'shECCCCCCD;
  localparam logic signed [31:0] ImMaxRst = 32'sh13333333;
  localparam logic [9:0] LimitRst = 10'd50;
  localparam logic [33:0] EscLimit = 34'h040000000;
  localparam logic [17:0] BlueScale = 18'd210;
endpackage
`default_nettype wire

// ----- sv/bse_ctrl.sv -----
`default_nettype none
module bse_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic             out_fire,
  input  wire bse_pkg::bse_sts_t sts,
  input  wire logic [9:0]       iter_limit,
  output bse_pkg::bse_cmd_t     cmd,
  output logic                  busy,
  output logic                  done,
  output logic [9:0]            count
);
  import bse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [9:0] count_r, count_nxt;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          count_nxt = '0;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        if (sts.map_done) begin
          cmd.map_re = 1'b1;
          cmd.map_im = 1'b1;
          cmd.init_z = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.cont && count_r < iter_limit) begin
          cmd.mul = 1'b1;
          state_nxt = S_UPD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        count_nxt = count_r + 10'd1;
        state_nxt = S_MUL;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign done  = (state_r == S_OUT);
  assign count = count_r;
endmodule
`default_nettype wire

// ----- sv/bse_dp.sv -----
`default_nettype none
module bse_dp #(
  parameter int IMG_WIDTH  = 1024,
  parameter int IMG_HEIGHT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bse_pkg::bse_cmd_t cmd,
  input  wire bse_pkg::bse_in_t  in_word,
  input  wire logic [9:0]        count,
  input  wire logic signed [31:0] re_min,
  input  wire logic signed [31:0] re_max,
  input  wire logic signed [31:0] im_min,
  input  wire logic signed [31:0] im_max,
  input  wire logic [9:0]        iter_limit,
  input  wire logic              start_mode,
  input  wire logic signed [31:0] start_re,
  input  wire logic signed [31:0] start_im,
  output bse_pkg::bse_sts_t      sts,
  output bse_pkg::bse_out_t      out_word
);
  import bse_pkg::*;

  localparam int QW = 44; // 33-bit span times 11-bit coord, signed
  localparam int NW = 42; // magnitude of that product
  localparam int KW = 55; // reciprocal scale: above NW plus divisor bits plus one
  localparam int AW = NW + KW;
  // ceil(2^KW / size), exact floor quotient for every NW-bit magnitude
  localparam logic [KW-1:0] RecipX =
    KW'(((64'd1 << KW) + 64'(IMG_WIDTH) - 64'd1) / 64'(IMG_WIDTH));
  localparam logic [KW-1:0] RecipY =
    KW'(((64'd1 << KW) + 64'(IMG_HEIGHT) - 64'd1) / 64'(IMG_HEIGHT));
  localparam logic [2:0] MapDone  = 3'd6;
  localparam logic [4:0] DivSteps = 5'd18;

  logic [9:0] px_r, py_r;
  logic signed [32:0] spx_r, spy_r;
  logic signed [QW-1:0] prx_r, pry_r;
  logic [2:0] mcnt_r;
  logic [NW-1:0] nmx_r, nmy_r;
  logic [AW-1:0] accx_r, accy_r;
  logic nx_r, ny_r;
  logic signed [31:0] cx_r, cy_r, zx_r, zy_r;
  logic [31:0] x2_r, y2_r, xy_r;
  logic [63:0] pxx_r, pyy_r, pxy_r;
  logic [17:0] dnum_r;
  logic [7:0]  dq_r;
  logic [17:0] drem_r;
  logic [4:0]  dcnt_r;
  logic [9:0]  cnt_r;

  // magnitude helpers
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [32:0] t;
    t = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
    return t[31:0] | {t[32], 31'd0};
  endfunction

  function automatic logic [31:0] sq_sat(input logic [63:0] p);
    return (|p[63:59]) ? 32'h7FFFFFFF : {1'b0, p[58:28]};
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sh07FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -34'sh080000000) return -32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat44(input logic signed [43:0] v);
    if (v > 44'sh0007FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -44'sh00080000000) return -32'sh80000000;
    return v[31:0];
  endfunction

  // window mapping: divide by the image size through a reciprocal multiply,
  // four 21x28 partial products summed in an accumulator
  logic [48:0] ppx, ppy;
  logic [AW-1:0] tx, ty;
  logic [NW-1:0] qx, qy;
  logic signed [QW-1:0] ox, oy;
  logic signed [QW-1:0] sumx, sumy;
  assign ppx = 49'(mcnt_r[2] ? nmx_r[41:21] : nmx_r[20:0])
             * 49'(mcnt_r[0] ? {1'b0, RecipX[54:28]} : RecipX[27:0]);
  assign ppy = 49'(mcnt_r[2] ? nmy_r[41:21] : nmy_r[20:0])
             * 49'(mcnt_r[0] ? {1'b0, RecipY[54:28]} : RecipY[27:0]);

  // place each partial product at its weight
  always_comb begin
    case ({mcnt_r[2], mcnt_r[0]})
      2'b00: begin
        tx = AW'(ppx);
        ty = AW'(ppy);
      end
      2'b01: begin
        tx = AW'(ppx) << 28;
        ty = AW'(ppy) << 28;
      end
      2'b10: begin
        tx = AW'(ppx) << 21;
        ty = AW'(ppy) << 21;
      end
      2'b11: begin
        tx = AW'(ppx) << 49;
        ty = AW'(ppy) << 49;
      end
      default: begin
        tx = '0;
        ty = '0;
      end
    endcase
  end

  assign qx = accx_r[AW-1:KW];
  assign qy = accy_r[AW-1:KW];
  assign ox = nx_r ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
  assign oy = ny_r ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
  assign sumx = ox + QW'(re_min);
  assign sumy = oy + QW'(im_min);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r  <= in_word.pixel_x;
      py_r  <= in_word.pixel_y;
      spx_r <= 33'(re_max) - 33'(re_min);
      spy_r <= 33'(im_max) - 33'(im_min);
      mcnt_r <= '0;
    end else if (mcnt_r == 3'd0) begin
      prx_r <= QW'(spx_r) * QW'($signed({1'b0, px_r}));
      pry_r <= QW'(spy_r) * QW'($signed({1'b0, py_r}));
      mcnt_r <= 3'd1;
    end else if (mcnt_r == 3'd1) begin
      nx_r <= prx_r[QW-1];
      ny_r <= pry_r[QW-1];
      nmx_r <= NW'(prx_r[QW-1] ? -prx_r : prx_r);
      nmy_r <= NW'(pry_r[QW-1] ? -pry_r : pry_r);
      accx_r <= '0;
      accy_r <= '0;
      mcnt_r <= 3'd2;
    end else if (mcnt_r < MapDone) begin
      accx_r <= accx_r + tx;
      accy_r <= accy_r + ty;
      mcnt_r <= mcnt_r + 3'd1;
    end
  end

  // iteration datapath: products in one cycle, update in the next
  always_ff @(posedge clk) begin
    if (cmd.map_re) cx_r <= sat44(sumx);
    if (cmd.map_im) cy_r <= sat44(sumy);
    if (cmd.init_z) begin
      zx_r <= start_mode ? start_re : '0;
      zy_r <= start_mode ? start_im : '0;
      x2_r <= '0;
      y2_r <= '0;
    end
    if (cmd.mul) begin
      pxx_r <= mag32(zx_r) * mag32(zx_r);
      pyy_r <= mag32(zy_r) * mag32(zy_r);
      pxy_r <= mag32(zx_r) * mag32(zy_r);
    end
    if (cmd.upd) begin
      x2_r <= sq_sat(pxx_r);
      y2_r <= sq_sat(pyy_r);
      xy_r <= sq_sat(pxy_r);
      zx_r <= sat34($signed({2'b0, sq_sat(pxx_r)}) - $signed({2'b0, sq_sat(pyy_r)})
                    + 34'(cx_r));
      zy_r <= sat34($signed({2'b0, sq_sat(pxy_r)}) + $signed({2'b0, sq_sat(pxy_r)})
                    + 34'(cy_r));
    end
  end

  // blue level by restoring division, one numerator bit a cycle
  logic [18:0] dtr;
  assign dtr = {drem_r, dnum_r[17]} - {9'd0, iter_limit};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r  <= count;
      dnum_r <= 18'(count) * BlueScale;
      drem_r <= '0;
      dq_r   <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step && dcnt_r != DivSteps) begin
      if (!dtr[18]) begin
        drem_r <= dtr[17:0];
        dq_r   <= {dq_r[6:0], 1'b1};
      end else begin
        drem_r <= {drem_r[16:0], dnum_r[17]};
        dq_r   <= {dq_r[6:0], 1'b0};
      end
      dnum_r <= {dnum_r[16:0], 1'b0};
      dcnt_r <= dcnt_r + 5'd1;
    end
  end

  assign sts.cont     = ({2'b0, x2_r} + {2'b0, y2_r}) <= EscLimit;
  assign sts.map_done = (mcnt_r == MapDone);
  assign sts.div_done = (dcnt_r == DivSteps);

  assign out_word.out_x      = px_r;
  assign out_word.out_y      = py_r;
  assign out_word.iter_count = cnt_r;
  assign out_word.blue_level = (iter_limit == 10'd0) ? 8'd0 : dq_r;
  assign out_word.on_canvas  = (px_r != 10'd0) && (py_r != 10'd0)
                               && (32'(px_r) < 32'(IMG_WIDTH))
                               && (32'(py_r) < 32'(IMG_HEIGHT));
endmodule
`default_nettype wire

// ----- sv/burning_ship_escape_time_top.sv -----
// flow: an accepted word goes through window mapping, then a multiply and an update
// step per iteration plus a final exit test, then the color divide, before out_valid
// throughput: one pixel at a time; the next word is accepted in the cycle after the
// result leaves
// reset: synchronous active low, restores the default window and limit
`default_nettype none
`include "burning_ship_escape_time_top_assert.svh"
module burning_ship_escape_time_top #(
  parameter int IMG_WIDTH  = 1024,
  parameter int IMG_HEIGHT = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bse_pkg::bse_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bse_pkg::bse_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);
  import bse_pkg::*;

  logic signed [31:0] re_min_r, re_max_r, im_min_r, im_max_r, st_re_r, st_im_r;
  logic [9:0] limit_r;
  logic       mode_r;
  bse_cmd_t cmd;
  bse_sts_t sts;
  logic busy, done;
  logic [9:0] count;
  logic in_fire, out_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_min_r <= ReMinRst;
      re_max_r <= ReMaxRst;
      im_min_r <= ImMinRst;
      im_max_r <= ImMaxRst;
      limit_r  <= LimitRst;
      mode_r   <= 1'b0;
      st_re_r  <= '0;
      st_im_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        3'(CfgReMin): re_min_r <= cfg_data;
        3'(CfgReMax): re_max_r <= cfg_data;
        3'(CfgImMin): im_min_r <= cfg_data;
        3'(CfgImMax): im_max_r <= cfg_data;
        3'(CfgLimit): limit_r  <= cfg_data[9:0];
        3'(CfgMode):  mode_r   <= cfg_data[0];
        3'(CfgStRe):  st_re_r  <= cfg_data;
        3'(CfgStIm):  st_im_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = busy;
  assign in_fire   = in_valid && !busy;
  assign out_valid = done;
  assign out_fire  = done && !out_stall;

  bse_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire), .sts(sts),
    .iter_limit(limit_r), .cmd(cmd), .busy(busy), .done(done), .count(count)
  );

  bse_dp #(.IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_word(in_data), .count(count),
    .re_min(re_min_r), .re_max(re_max_r), .im_min(im_min_r), .im_max(im_max_r),
    .iter_limit(limit_r), .start_mode(mode_r), .start_re(st_re_r),
    .start_im(st_im_r), .sts(sts), .out_word(out_data)
  );

  `BSE_ASSERT_IMP(a_no_accept_busy, busy, !in_fire)
  `BSE_ASSERT_IMP(a_count_limit, done, out_data.iter_count <= limit_r)
  `BSE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// pixel results expected from the escape-time iteration
class pixel_scoreboard;
  logic signed [31:0] win_re_lo, win_re_hi, win_im_lo, win_im_hi;
  logic [9:0] max_iter;
  logic seed_on;
  logic signed [31:0] seed_re, seed_im;
  bse_pkg::bse_out_t pending[$];
  int errors;

  function void reset_regs();
    win_re_lo = bse_pkg::ReMinRst;
    win_re_hi = bse_pkg::ReMaxRst;
    win_im_lo = bse_pkg::ImMinRst;
    win_im_hi = bse_pkg::ImMaxRst;
    max_iter = bse_pkg::LimitRst;
    seed_on = 1'b0;
    seed_re = '0;
    seed_im = '0;
    errors = 0;
  endfunction

  function void write_reg(int idx, logic [31:0] v);
    case (idx)
      bse_pkg::CfgReMin: win_re_lo = v;
      bse_pkg::CfgReMax: win_re_hi = v;
      bse_pkg::CfgImMin: win_im_lo = v;
      bse_pkg::CfgImMax: win_im_hi = v;
      bse_pkg::CfgLimit: max_iter = v[9:0];
      bse_pkg::CfgMode:  seed_on = v[0];
      bse_pkg::CfgStRe:  seed_re = v;
      bse_pkg::CfgStIm:  seed_im = v;
      default: ;
    endcase
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // |a*b| >> 28, clamped to max positive
  function longint mag_product(longint a, longint b);
    logic [63:0] ua, ub, p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = (ua * ub) >> 28;
    if (p > 64'd2147483647) return 64'sd2147483647;
    return longint'(p);
  endfunction

  function longint map_axis(longint lo, longint hi, int coord);
    longint prod;
    prod = (hi - lo) * longint'(coord);
    return clamp32(lo + prod / 1024);
  endfunction

  function void note_pixel(bse_pkg::bse_in_t w);
    bse_pkg::bse_out_t r;
    longint cx, cy, zx, zy, x2, y2, xy;
    int n;
    cx = map_axis(win_re_lo, win_re_hi, w.pixel_x);
    cy = map_axis(win_im_lo, win_im_hi, w.pixel_y);
    zx = seed_on ? longint'(seed_re) : 0;
    zy = seed_on ? longint'(seed_im) : 0;
    x2 = 0;
    y2 = 0;
    n = 0;
    while (x2 + y2 <= 64'sd1073741824 && n < max_iter) begin
      xy = mag_product(zx, zy);
      x2 = mag_product(zx, zx);
      y2 = mag_product(zy, zy);
      zx = clamp32(x2 - y2 + cx);
      zy = clamp32(xy + xy + cy);
      n++;
    end
    r.out_x = w.pixel_x;
    r.out_y = w.pixel_y;
    r.iter_count = n[9:0];
    r.blue_level = (max_iter != 0) ? 8'((n * 210) / max_iter) : 8'd0;
    r.on_canvas = (w.pixel_x > 0) && (w.pixel_y > 0);
    pending.push_back(r);
  endfunction

  function void check_pixel(bse_pkg::bse_out_t got);
    bse_pkg::bse_out_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word %h", $time, got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.out_x !== e.out_x || got.out_y !== e.out_y ||
        got.iter_count !== e.iter_count || got.blue_level !== e.blue_level ||
        got.on_canvas !== e.on_canvas) begin
      $display("%0t: mismatch expected x=%0d y=%0d n=%0d b=%0d c=%0d actual x=%0d y=%0d n=%0d b=%0d c=%0d",
               $time, e.out_x, e.out_y, e.iter_count, e.blue_level, e.on_canvas,
               got.out_x, got.out_y, got.iter_count, got.blue_level, got.on_canvas);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bse_pkg::bse_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bse_pkg::bse_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pixel_scoreboard sb;
  bit hold_long = 1'b0;

  always #5 clk = ~clk;

  burning_ship_escape_time_top i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // register write, block idle
  task automatic write_reg(int idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // offer one pixel word and hold until accepted; valid stays up for a
  // back-to-back word and drops at the start of a gap
  task automatic send_pixel(logic [9:0] px, logic [9:0] py, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data <= '{pixel_x: px, pixel_y: py};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(in_data);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function logic [31:0] rnd_edge();
    case ($urandom_range(0, 3))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      default: return $urandom_range(0, 32'h40000000) - 32'h20000000;
    endcase
  endfunction

  // result side: sample at rising edge, stall changes at falling edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_data);
  end

  initial begin : stall_gen
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_long = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g != 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int lim;
    sb = new();
    sb.reset_regs();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, edges and interior points
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd0, 10'd512, 0);
    send_pixel(10'd512, 10'd0, 0);
    send_pixel(10'd1, 10'd1, 0);
    send_pixel(10'h2AA, 10'h155, 0);
    send_pixel(10'h155, 10'h2AA, 0);
    send_pixel(10'd700, 10'd400, 0);
    drain();
    repeat (80) @(negedge clk);
    // zero limit, then limit one, then max with start point
    write_reg(bse_pkg::CfgLimit, 32'd0);
    send_pixel(10'd300, 10'd300, 0);
    send_pixel(10'd0, 10'd1023, 0);
    drain();
    repeat (80) @(negedge clk);
    write_reg(bse_pkg::CfgLimit, 32'd1);
    send_pixel(10'd300, 10'd300, 0);
    drain();
    repeat (80) @(negedge clk);
    write_reg(bse_pkg::CfgLimit, 32'd1023);
    write_reg(bse_pkg::CfgMode, 32'd1);
    write_reg(bse_pkg::CfgStRe, 32'h7FFFFFFF);
    write_reg(bse_pkg::CfgStIm, 32'h80000000);
    write_reg(bse_pkg::CfgReMin, 32'h80000000);
    write_reg(bse_pkg::CfgReMax, 32'h7FFFFFFF);
    write_reg(bse_pkg::CfgImMin, 32'h7FFFFFFF);
    write_reg(bse_pkg::CfgImMax, 32'h80000000);
    send_pixel(10'd1023, 10'd0, 0);
    send_pixel(10'd512, 10'd512, 0);
    drain();
    repeat (80) @(negedge clk);
    write_reg(bse_pkg::CfgStRe, 32'd0);
    write_reg(bse_pkg::CfgStIm, 32'd0);
    write_reg(bse_pkg::CfgReMin, bse_pkg::ReMinRst);
    write_reg(bse_pkg::CfgReMax, bse_pkg::ReMaxRst);
    write_reg(bse_pkg::CfgImMin, bse_pkg::ImMinRst);
    write_reg(bse_pkg::CfgImMax, bse_pkg::ImMaxRst);
    send_pixel(10'd400, 10'd512, 0); // interior, runs to limit
    drain();
    repeat (80) @(negedge clk);

    // random phases with varied settings; limits mostly small
    for (int ph = 0; ph < 10; ph++) begin
      lim = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 64);
      write_reg(bse_pkg::CfgLimit, lim);
      write_reg(bse_pkg::CfgMode, $urandom_range(0, 1));
      write_reg(bse_pkg::CfgStRe, $urandom_range(0, 32'h30000000) - 32'h18000000);
      write_reg(bse_pkg::CfgStIm, $urandom_range(0, 32'h30000000) - 32'h18000000);
      if (ph % 3 == 2) begin
        write_reg(bse_pkg::CfgReMin, rnd_edge());
        write_reg(bse_pkg::CfgReMax, rnd_edge());
        write_reg(bse_pkg::CfgImMin, rnd_edge());
        write_reg(bse_pkg::CfgImMax, rnd_edge());
      end else begin
        write_reg(bse_pkg::CfgReMin, bse_pkg::ReMinRst);
        write_reg(bse_pkg::CfgReMax, bse_pkg::ReMaxRst);
        write_reg(bse_pkg::CfgImMin, bse_pkg::ImMinRst);
        write_reg(bse_pkg::CfgImMax, bse_pkg::ImMaxRst);
      end
      if (ph == 4) hold_long = 1'b1;
      for (int k = 0; k < 93; k++)
        send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), (k % 20) < 14);
      drain();
      repeat (80) @(negedge clk);
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- burning_ship_escape_time_top.f -----
+incdir+sv
sv/bse_pkg.sv
sv/bse_ctrl.sv
sv/bse_dp.sv
sv/burning_ship_escape_time_top.sv
tb/tb_top.sv
